// ===== sv/pidps_pkg.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// PID position loop package
// Shared constants, reset values and register indexes for the slew-limited
// position PID block.
// -----------------------------------------------------------------------------
package pidps_pkg;

	localparam int CFG_DATA_BITS  = 32;
	localparam int CFG_INDEX_BITS = 3;
	localparam int GAIN_BITS      = 32;
	localparam int ESUM_BITS      = 32;
	localparam int SLEW_BITS      = 8;
	localparam int FRAC_BITS      = 24;
	localparam int TOT_BITS       = 66;

	localparam logic signed [GAIN_BITS-1:0] PROP_GAIN_RST  = 32'sd13421773;
	localparam logic signed [GAIN_BITS-1:0] INTEG_GAIN_RST = 32'sd5872;
	localparam logic signed [GAIN_BITS-1:0] DERIV_GAIN_RST = 32'sd71303168;
	localparam logic [SLEW_BITS-1:0]        SLEW_LIMIT_RST = 8'd15;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_SETPOINT   = 3'd0,
		REG_PROP_GAIN  = 3'd1,
		REG_INTEG_GAIN = 3'd2,
		REG_DERIV_GAIN = 3'd3,
		REG_SLEW_LIMIT = 3'd4
	} reg_idx_t;

endpackage

// ===== sv/pidps_sample_if.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Position sample channel
// Valid/ready channel carrying one signed position sample per transfer.
// -----------------------------------------------------------------------------
interface pidps_sample_if #(
	parameter int SAMPLE_BITS = 16
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] position_sample;

	modport source (output valid, output position_sample, input ready);
	modport sink   (input valid, input position_sample, output ready);
endinterface

// ===== sv/pidps_drive_if.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Drive power channel
// Valid/ready channel carrying one signed motor drive value per transfer.
// -----------------------------------------------------------------------------
interface pidps_drive_if #(
	parameter int DRIVE_BITS = 8
);
	logic                         valid;
	logic                         ready;
	logic signed [DRIVE_BITS-1:0] drive_power;

	modport source (output valid, output drive_power, input ready);
	modport sink   (input valid, input drive_power, output ready);
endinterface

// ===== sv/pid_position_slew_limited.sv =====
`timescale 1ns / 1ps
// Each result passes the error, product, sum, clamp and slew registers.
// Throughput: one sample per cycle while drive.ready is high; each stage
// holds one item, moving on once the next stage is free; bubbles close up.
// Reset: asynchronous, clears the pipeline, the error sum, the previous error
// and the previous drive, and loads the register defaults.
// -----------------------------------------------------------------------------
// Slew-limited position PID loop
// Five-stage pipeline: error, gain products, sum, clamp, slew limit.
// -----------------------------------------------------------------------------
module pid_position_slew_limited
	import pidps_pkg::*;
#(
	parameter int SAMPLE_BITS = 16,
	parameter int DRIVE_LIMIT = 127
) (
	input  logic                      clk,
	input  logic                      arst_n,
	pidps_sample_if.sink              sample,
	pidps_drive_if.source             drive,
	input  logic                      cfg_write,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

	localparam int DRIVE_BITS = $clog2(DRIVE_LIMIT + 1) + 1;
	localparam int STAGES     = 5;

	logic signed [SAMPLE_BITS-1:0] setpoint;
	logic signed [GAIN_BITS-1:0]   prop_gain;
	logic signed [GAIN_BITS-1:0]   integ_gain;
	logic signed [GAIN_BITS-1:0]   deriv_gain;
	logic [SLEW_BITS-1:0]          slew_limit;

	logic signed [SAMPLE_BITS:0]                err_s1;
	logic signed [SAMPLE_BITS+1:0]              derr_s1;
	logic signed [ESUM_BITS-1:0]                esum_s1;
	logic signed [SAMPLE_BITS+GAIN_BITS:0]      p_s2;
	logic signed [ESUM_BITS+GAIN_BITS-1:0]      i_s2;
	logic signed [SAMPLE_BITS+GAIN_BITS+1:0]    d_s2;
	logic signed [DRIVE_BITS-1:0]               clamp_s4;
	logic signed [DRIVE_BITS-1:0]               drive_q;

	// valid_q[k] marks an item in stage k+1; free[k] says stage k+1 can load.
	logic [STAGES-1:0] valid_q;
	logic [STAGES-1:0] free;
	logic [STAGES-1:0] load;
	logic [STAGES-1:0] upstream_valid;

	always_comb begin
		upstream_valid = {valid_q[STAGES-2:0], sample.valid};
		free[STAGES-1] = !valid_q[STAGES-1] || drive.ready;
		for (int k = STAGES - 2; k >= 0; k--)
			free[k] = !valid_q[k] || free[k+1];
		load = upstream_valid & free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= '0;
		else
			valid_q <= (free & upstream_valid) | (~free & valid_q);
	end

	assign sample.ready      = free[0];
	assign drive.valid       = valid_q[STAGES-1];
	assign drive.drive_power = drive_q;

	pidps_regs #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_regs (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.setpoint   (setpoint),
		.prop_gain  (prop_gain),
		.integ_gain (integ_gain),
		.deriv_gain (deriv_gain),
		.slew_limit (slew_limit)
	);

	pidps_error #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_error (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load[0]),
		.sample   (sample.position_sample),
		.setpoint (setpoint),
		.err_s1   (err_s1),
		.derr_s1  (derr_s1),
		.esum_s1  (esum_s1)
	);

	pidps_mult #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_mult (
		.clk        (clk),
		.load       (load[1]),
		.err_s1     (err_s1),
		.derr_s1    (derr_s1),
		.esum_s1    (esum_s1),
		.prop_gain  (prop_gain),
		.integ_gain (integ_gain),
		.deriv_gain (deriv_gain),
		.p_s2       (p_s2),
		.i_s2       (i_s2),
		.d_s2       (d_s2)
	);

	pidps_drive #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.DRIVE_LIMIT(DRIVE_LIMIT),
		.DRIVE_BITS (DRIVE_BITS)
	) u_drive (
		.clk      (clk),
		.load_s3  (load[2]),
		.load_s4  (load[3]),
		.p_s2     (p_s2),
		.i_s2     (i_s2),
		.d_s2     (d_s2),
		.clamp_s4 (clamp_s4)
	);

	pidps_slew #(
		.DRIVE_BITS(DRIVE_BITS)
	) u_slew (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (load[4]),
		.clamp_s4   (clamp_s4),
		.slew_limit (slew_limit),
		.drive_q    (drive_q)
	);

endmodule

// ===== sv/pidps_regs.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Configuration registers
// Setpoint, the three loop gains and the slew limit, written by index.
// -----------------------------------------------------------------------------
module pidps_regs
	import pidps_pkg::*;
#(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
	input  logic [CFG_DATA_BITS-1:0]      cfg_data,
	output logic signed [SAMPLE_BITS-1:0] setpoint,
	output logic signed [GAIN_BITS-1:0]   prop_gain,
	output logic signed [GAIN_BITS-1:0]   integ_gain,
	output logic signed [GAIN_BITS-1:0]   deriv_gain,
	output logic [SLEW_BITS-1:0]          slew_limit
);

	logic signed [SAMPLE_BITS-1:0] setpoint_q;
	logic signed [GAIN_BITS-1:0]   prop_gain_q;
	logic signed [GAIN_BITS-1:0]   integ_gain_q;
	logic signed [GAIN_BITS-1:0]   deriv_gain_q;
	logic [SLEW_BITS-1:0]          slew_limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setpoint_q   <= '0;
			prop_gain_q  <= PROP_GAIN_RST;
			integ_gain_q <= INTEG_GAIN_RST;
			deriv_gain_q <= DERIV_GAIN_RST;
			slew_limit_q <= SLEW_LIMIT_RST;
		end else if (cfg_write) begin
			case (reg_idx_t'(cfg_index))
				REG_SETPOINT:   setpoint_q   <= $signed(cfg_data[SAMPLE_BITS-1:0]);
				REG_PROP_GAIN:  prop_gain_q  <= $signed(cfg_data[GAIN_BITS-1:0]);
				REG_INTEG_GAIN: integ_gain_q <= $signed(cfg_data[GAIN_BITS-1:0]);
				REG_DERIV_GAIN: deriv_gain_q <= $signed(cfg_data[GAIN_BITS-1:0]);
				REG_SLEW_LIMIT: slew_limit_q <= cfg_data[SLEW_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign setpoint   = setpoint_q;
	assign prop_gain  = prop_gain_q;
	assign integ_gain = integ_gain_q;
	assign deriv_gain = deriv_gain_q;
	assign slew_limit = slew_limit_q;

endmodule

// ===== sv/pidps_error.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Error stage
// Forms the error, its saturating running sum and its change since the last
// sample, and keeps the error state.
// -----------------------------------------------------------------------------
module pidps_error
	import pidps_pkg::*;
#(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          load,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic signed [SAMPLE_BITS-1:0] setpoint,
	output logic signed [SAMPLE_BITS:0]   err_s1,
	output logic signed [SAMPLE_BITS+1:0] derr_s1,
	output logic signed [ESUM_BITS-1:0]   esum_s1
);

	localparam int ERR_BITS = SAMPLE_BITS + 1;
	localparam logic signed [ESUM_BITS-1:0] ESUM_MAX = {1'b0, {(ESUM_BITS-1){1'b1}}};
	localparam logic signed [ESUM_BITS-1:0] ESUM_MIN = {1'b1, {(ESUM_BITS-1){1'b0}}};

	logic signed [ERR_BITS-1:0]   error_q;
	logic signed [ESUM_BITS-1:0]  error_sum_q;
	logic signed [ERR_BITS-1:0]   err;
	logic signed [ESUM_BITS:0]    sum_wide;
	logic signed [ESUM_BITS-1:0]  sum_sat;
	logic signed [ERR_BITS:0]     derr;

	always_comb begin
		err      = ERR_BITS'(setpoint) - ERR_BITS'(sample);
		sum_wide = (ESUM_BITS+1)'(error_sum_q) + (ESUM_BITS+1)'(err);
		// The top two bits differ only when the sum has left the 32-bit range.
		if (sum_wide[ESUM_BITS] != sum_wide[ESUM_BITS-1])
			sum_sat = sum_wide[ESUM_BITS] ? ESUM_MIN : ESUM_MAX;
		else
			sum_sat = sum_wide[ESUM_BITS-1:0];
		derr = (ERR_BITS+1)'(err) - (ERR_BITS+1)'(error_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			error_q     <= '0;
			error_sum_q <= '0;
		end else if (load) begin
			error_q     <= err;
			error_sum_q <= sum_sat;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			err_s1  <= err;
			derr_s1 <= derr;
			esum_s1 <= sum_sat;
		end
	end

endmodule

// ===== sv/pidps_mult.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Gain multipliers
// The three independent gain products, one multiplier each, registered.
// -----------------------------------------------------------------------------
module pidps_mult
	import pidps_pkg::*;
#(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                                   clk,
	input  logic                                   load,
	input  logic signed [SAMPLE_BITS:0]            err_s1,
	input  logic signed [SAMPLE_BITS+1:0]          derr_s1,
	input  logic signed [ESUM_BITS-1:0]            esum_s1,
	input  logic signed [GAIN_BITS-1:0]            prop_gain,
	input  logic signed [GAIN_BITS-1:0]            integ_gain,
	input  logic signed [GAIN_BITS-1:0]            deriv_gain,
	output logic signed [SAMPLE_BITS+GAIN_BITS:0]   p_s2,
	output logic signed [ESUM_BITS+GAIN_BITS-1:0]  i_s2,
	output logic signed [SAMPLE_BITS+GAIN_BITS+1:0] d_s2
);

	localparam int P_BITS = SAMPLE_BITS + GAIN_BITS + 1;
	localparam int I_BITS = ESUM_BITS + GAIN_BITS;
	localparam int D_BITS = SAMPLE_BITS + GAIN_BITS + 2;

	always_ff @(posedge clk) begin
		if (load) begin
			p_s2 <= P_BITS'(err_s1) * P_BITS'(prop_gain);
			i_s2 <= I_BITS'(esum_s1) * I_BITS'(integ_gain);
			d_s2 <= D_BITS'(derr_s1) * D_BITS'(deriv_gain);
		end
	end

endmodule

// ===== sv/pidps_drive.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Drive sum and clamp
// Adds the three terms, drops the fraction with truncation toward zero and
// clamps the result to the drive limit.
// -----------------------------------------------------------------------------
module pidps_drive
	import pidps_pkg::*;
#(
	parameter int SAMPLE_BITS = 16,
	parameter int DRIVE_LIMIT = 127,
	parameter int DRIVE_BITS  = 8
) (
	input  logic                                    clk,
	input  logic                                    load_s3,
	input  logic                                    load_s4,
	input  logic signed [SAMPLE_BITS+GAIN_BITS:0]   p_s2,
	input  logic signed [ESUM_BITS+GAIN_BITS-1:0]   i_s2,
	input  logic signed [SAMPLE_BITS+GAIN_BITS+1:0] d_s2,
	output logic signed [DRIVE_BITS-1:0]            clamp_s4
);

	localparam int Q_BITS = TOT_BITS - FRAC_BITS;
	localparam logic signed [TOT_BITS-1:0] ROUND_BIAS =
		TOT_BITS'((64'(1) << FRAC_BITS) - 64'(1));
	localparam logic signed [Q_BITS-1:0] POS_LIMIT = Q_BITS'(DRIVE_LIMIT);
	localparam logic signed [Q_BITS-1:0] NEG_LIMIT = -Q_BITS'(DRIVE_LIMIT);

	logic signed [TOT_BITS-1:0] total_s3;
	logic signed [TOT_BITS-1:0] biased;
	logic signed [Q_BITS-1:0]   quot;
	logic signed [DRIVE_BITS-1:0] clamped;

	always_ff @(posedge clk) begin
		if (load_s3)
			total_s3 <= TOT_BITS'(p_s2) + TOT_BITS'(i_s2) + TOT_BITS'(d_s2);
	end

	always_comb begin
		// A negative total is biased up so the arithmetic shift rounds toward zero.
		biased = total_s3 + (total_s3[TOT_BITS-1] ? ROUND_BIAS : '0);
		quot   = biased[TOT_BITS-1:FRAC_BITS];
		if (quot > POS_LIMIT)
			clamped = DRIVE_BITS'(DRIVE_LIMIT);
		else if (quot < NEG_LIMIT)
			clamped = -DRIVE_BITS'(DRIVE_LIMIT);
		else
			clamped = quot[DRIVE_BITS-1:0];
	end

	always_ff @(posedge clk) begin
		if (load_s4)
			clamp_s4 <= clamped;
	end

endmodule

// ===== sv/pidps_slew.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Slew limiter
// Limits the step of the drive against the previous drive; the previous
// drive register is also the output register.
// -----------------------------------------------------------------------------
module pidps_slew
	import pidps_pkg::*;
#(
	parameter int DRIVE_BITS = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         load,
	input  logic signed [DRIVE_BITS-1:0] clamp_s4,
	input  logic [SLEW_BITS-1:0]         slew_limit,
	output logic signed [DRIVE_BITS-1:0] drive_q
);

	localparam int DW = ((DRIVE_BITS > SLEW_BITS + 1) ? DRIVE_BITS : SLEW_BITS + 1) + 2;

	logic signed [DW-1:0]         diff;
	logic signed [DW-1:0]         step;
	logic signed [DW-1:0]         limited;
	logic signed [DRIVE_BITS-1:0] next_drive;

	always_comb begin
		step = DW'($signed({1'b0, slew_limit}));
		diff = DW'(clamp_s4) - DW'(drive_q);
		if (diff > step)
			limited = DW'(drive_q) + step;
		else if (diff < -step)
			limited = DW'(drive_q) - step;
		else
			limited = DW'(clamp_s4);
		next_drive = limited[DRIVE_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			drive_q <= '0;
		else if (load)
			drive_q <= next_drive;
	end

endmodule

// ===== dv/pidps_loop_checker.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// PID position loop checker
// Watches the sample and drive channels and the register write port. It keeps
// its own copy of the loop state, predicts the drive for every accepted sample
// and compares it with the drive transfers in order.
// -----------------------------------------------------------------------------
module pidps_loop_checker
	import pidps_pkg::*;
#(
	parameter int SAMPLE_BITS = 16,
	parameter int DRIVE_LIMIT = 127
) (
	input  logic                      clk,
	input  logic                      arst_n,
	pidps_sample_if                   sample_mon,
	pidps_drive_if                    drive_mon,
	input  logic                      cfg_write,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data,
	output int                        fail_count,
	output int                        pending
);

	localparam int DRIVE_BITS = 8;

	logic signed [SAMPLE_BITS-1:0] setpoint_r;
	logic signed [GAIN_BITS-1:0]   kp_r;
	logic signed [GAIN_BITS-1:0]   ki_r;
	logic signed [GAIN_BITS-1:0]   kd_r;
	logic [SLEW_BITS-1:0]          slew_r;

	logic signed [ESUM_BITS-1:0]   err_sum;
	logic signed [SAMPLE_BITS:0]   last_err;
	logic signed [DRIVE_BITS-1:0]  last_drive;

	logic signed [DRIVE_BITS-1:0]  drive_q[$];
	logic signed [DRIVE_BITS-1:0]  want;

	// Advances the loop by one sample and returns the drive it should produce.
	function automatic logic signed [DRIVE_BITS-1:0] step_loop(
		input logic signed [SAMPLE_BITS-1:0] pos
	);
		longint err;
		longint sum;
		longint total;
		longint drv;
		longint diff;
		longint slew;
		longint sum_max;
		longint sum_min;
		sum_max = (longint'(1) <<< (ESUM_BITS - 1)) - 1;
		sum_min = -(longint'(1) <<< (ESUM_BITS - 1));
		err = longint'(setpoint_r) - longint'(pos);
		sum = longint'(err_sum) + err;
		if (sum > sum_max)
			sum = sum_max;
		else if (sum < sum_min)
			sum = sum_min;
		total = err * longint'(kp_r) + sum * longint'(ki_r)
			+ (err - longint'(last_err)) * longint'(kd_r);
		// Signed division truncates toward zero, as the fixed-point scaling needs.
		drv = total / (longint'(1) <<< FRAC_BITS);
		if (drv > DRIVE_LIMIT)
			drv = DRIVE_LIMIT;
		else if (drv < -DRIVE_LIMIT)
			drv = -DRIVE_LIMIT;
		slew = longint'(slew_r);
		diff = drv - longint'(last_drive);
		if (diff > slew)
			drv = longint'(last_drive) + slew;
		else if (diff < -slew)
			drv = longint'(last_drive) - slew;
		err_sum = ESUM_BITS'(sum);
		last_err = (SAMPLE_BITS + 1)'(err);
		last_drive = DRIVE_BITS'(drv);
		return last_drive;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setpoint_r = '0;
			kp_r = PROP_GAIN_RST;
			ki_r = INTEG_GAIN_RST;
			kd_r = DERIV_GAIN_RST;
			slew_r = SLEW_LIMIT_RST;
			err_sum = '0;
			last_err = '0;
			last_drive = '0;
			drive_q.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (drive_mon.valid && drive_mon.ready) begin
				if (drive_q.size() == 0) begin
					$error("drive_power: transfer of %0d with nothing expected",
						drive_mon.drive_power);
					fail_count++;
				end else begin
					want = drive_q.pop_front();
					if (want !== drive_mon.drive_power) begin
						$error("drive_power: expected %0d, actual %0d",
							want, drive_mon.drive_power);
						fail_count++;
					end
				end
			end
			if (cfg_write) begin
				case (reg_idx_t'(cfg_index))
					REG_SETPOINT:   setpoint_r = cfg_data[SAMPLE_BITS-1:0];
					REG_PROP_GAIN:  kp_r = cfg_data[GAIN_BITS-1:0];
					REG_INTEG_GAIN: ki_r = cfg_data[GAIN_BITS-1:0];
					REG_DERIV_GAIN: kd_r = cfg_data[GAIN_BITS-1:0];
					REG_SLEW_LIMIT: slew_r = cfg_data[SLEW_BITS-1:0];
					default: ;
				endcase
			end
			if (sample_mon.valid && sample_mon.ready)
				drive_q.push_back(step_loop(sample_mon.position_sample));
			pending = drive_q.size();
		end
	end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Slew-limited position PID testbench
// Drives position samples and register writes into the loop, with random
// gaps and stalls on both channels. A short directed part covers the field
// extremes and the slew corner cases, a short burst pushes the error sum one
// way and then the other, and randomised phases follow with fresh settings.
// -----------------------------------------------------------------------------
module tb;
	import pidps_pkg::*;

	localparam int SAMPLE_BITS   = 16;
	localparam int DRIVE_LIMIT   = 127;
	localparam int CLK_PERIOD    = 4;
	localparam int RESET_CYCLES  = 9;
	localparam int LATENCY       = 5;
	localparam int RANDOM_PHASES = 6;
	localparam int PHASE_ITEMS   = 150;
	localparam int HOLD_AT       = 200;
	localparam int HOLD_CYCLES   = 64;
	localparam int WIND_UP       = 10;
	localparam int WIND_DOWN     = 20;
	localparam int WIND_BACK     = 10;
	localparam int TIMEOUT_NS    = 20_000_000;

	localparam logic [CFG_INDEX_BITS-1:0] REG_FIRST_UNUSED = 3'd5;
	localparam logic [CFG_INDEX_BITS-1:0] REG_LAST_UNUSED  = 3'd7;

	logic                      clk;
	logic                      arst_n;
	logic                      cfg_write;
	logic [CFG_INDEX_BITS-1:0] cfg_index;
	logic [CFG_DATA_BITS-1:0]  cfg_data;

	bit                        fast_flow;
	bit                        random_phase;
	int                        tx_stretch;
	int                        fail_count;
	int                        pending;
	logic signed [15:0]        cur_setpoint;

	pidps_sample_if #(.SAMPLE_BITS(SAMPLE_BITS)) sample_ch ();
	pidps_drive_if  #(.DRIVE_BITS(8))            drive_ch ();

	pid_position_slew_limited #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.DRIVE_LIMIT(DRIVE_LIMIT)
	) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample    (sample_ch),
		.drive     (drive_ch),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	pidps_loop_checker #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.DRIVE_LIMIT(DRIVE_LIMIT)
	) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.sample_mon (sample_ch),
		.drive_mon  (drive_ch),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial clk = 1'b0;
	always #(CLK_PERIOD / 2) clk = ~clk;

	// Mostly short random gaps, now and then a stretch with none at all.
	function automatic int draw_gap(inout int stretch);
		if (stretch > 0) begin
			stretch--;
			return 0;
		end
		if ($urandom_range(0, 39) == 0) begin
			stretch = $urandom_range(10, 30);
			return 0;
		end
		return $urandom_range(0, 3);
	endfunction

	function automatic logic [31:0] pick_gain(input int mag_bits);
		logic [31:0] g;
		case ($urandom_range(0, 5))
			0: g = 32'h7FFF_FFFF;
			1: g = 32'h8000_0000;
			2: g = '0;
			3, 4: begin
				g = $urandom_range(0, 1 << mag_bits);
				if ($urandom_range(0, 1) == 1)
					g = -g;
			end
			default: g = $urandom();
		endcase
		return g;
	endfunction

	function automatic logic [7:0] pick_slew();
		case ($urandom_range(0, 5))
			0: return 8'd0;
			1: return 8'd254;
			2: return 8'd255;
			3: return 8'($urandom_range(0, 255));
			default: return 8'($urandom_range(1, 30));
		endcase
	endfunction

	function automatic logic signed [15:0] pick_setpoint();
		case ($urandom_range(0, 4))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2: return 16'sh0000;
			default: return 16'($urandom());
		endcase
	endfunction

	// Most samples sit near the setpoint so that the drive is not always clamped.
	function automatic logic signed [15:0] pick_sample();
		int offs;
		if ($urandom_range(0, 9) < 6) begin
			offs = $urandom_range(0, 512);
			return 16'(int'(cur_setpoint) + offs - 256);
		end
		return 16'($urandom());
	endfunction

	task automatic cfg_wr(input logic [CFG_INDEX_BITS-1:0] idx,
		input logic [CFG_DATA_BITS-1:0] data);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	// Upper bits carry junk; only the register's own width should count.
	task automatic put_setpoint(input logic signed [15:0] sp);
		logic [31:0] junk;
		junk = $urandom();
		cur_setpoint = sp;
		cfg_wr(REG_SETPOINT, {junk[31:16], sp});
	endtask

	task automatic put_slew(input logic [7:0] s);
		logic [31:0] junk;
		junk = $urandom();
		cfg_wr(REG_SLEW_LIMIT, {junk[31:8], s});
	endtask

	task automatic put_gains(input logic [31:0] kp, input logic [31:0] ki,
		input logic [31:0] kd);
		cfg_wr(REG_PROP_GAIN, kp);
		cfg_wr(REG_INTEG_GAIN, ki);
		cfg_wr(REG_DERIV_GAIN, kd);
	endtask

	task automatic send_sample(input logic signed [15:0] pos);
		int gap;
		gap = fast_flow ? 0 : draw_gap(tx_stretch);
		@(negedge clk);
		if (gap > 0) begin
			sample_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.position_sample <= pos;
		do @(posedge clk); while (!sample_ch.ready);
	endtask

	// Drops valid, waits for every outstanding drive, then lets the pipe empty.
	task automatic settle();
		@(negedge clk);
		sample_ch.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (LATENCY) @(negedge clk);
	endtask

	initial begin : sink_side
		int gap;
		int rx_stretch;
		int rand_rx;
		bit hold_done;
		drive_ch.ready = 1'b0;
		rx_stretch = 0;
		rand_rx = 0;
		hold_done = 1'b0;
		@(posedge arst_n);
		forever begin
			gap = fast_flow ? 0 : draw_gap(rx_stretch);
			// One long hold-off so that the pipeline fills and the input stalls.
			if (random_phase && !hold_done && rand_rx >= HOLD_AT) begin
				gap = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			@(negedge clk);
			if (gap > 0) begin
				drive_ch.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			drive_ch.ready <= 1'b1;
			do @(posedge clk); while (!drive_ch.valid);
			if (random_phase)
				rand_rx++;
		end
	end

	initial begin : stimulus
		int idx;
		logic [31:0] junk;
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = REG_SETPOINT;
		cfg_data = '0;
		sample_ch.valid = 1'b0;
		sample_ch.position_sample = '0;
		fast_flow = 1'b0;
		random_phase = 1'b0;
		tx_stretch = 0;
		cur_setpoint = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// Register defaults, sample extremes.
		send_sample(16'sh0000);
		send_sample(16'sh7FFF);
		send_sample(16'sh8000);
		send_sample(-16'sd1);
		send_sample(16'sd1);
		settle();

		// Widest errors, extreme gains, a slew limit of 255, unused indexes.
		put_setpoint(16'sh8000);
		put_slew(8'd255);
		put_gains(32'h7FFF_FFFF, 32'h0000_0000, 32'h8000_0000);
		for (idx = REG_FIRST_UNUSED; idx <= REG_LAST_UNUSED; idx++) begin
			junk = $urandom();
			cfg_wr(CFG_INDEX_BITS'(idx), junk);
		end
		send_sample(16'sh7FFF);
		send_sample(16'sh8000);
		send_sample(16'sh0000);
		send_sample(16'sh7FFF);
		settle();

		// A swing from one clamp to the other equals the slew limit exactly.
		put_setpoint(16'sh0000);
		put_slew(8'd254);
		put_gains(32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0000);
		send_sample(16'sh8000);
		send_sample(16'sh7FFF);
		send_sample(16'sh8000);
		send_sample(16'sd5);
		send_sample(16'sh0000);
		settle();

		// With a zero slew limit the drive must not move at all.
		put_slew(8'd0);
		put_gains(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_sample(16'sd100);
		send_sample(-16'sd100);
		send_sample(16'sh7FFF);
		send_sample(16'sh8000);
		settle();

		// Unity proportional gain, drive creeps by one per sample.
		put_slew(8'd1);
		put_gains(32'h0100_0000, 32'h0000_0000, 32'h0000_0000);
		send_sample(-16'sd3);
		send_sample(-16'sd3);
		send_sample(-16'sd3);
		send_sample(16'sd3);
		settle();

		// Push the error sum with the widest errors one way, then the other, then back.
		put_setpoint(16'sh7FFF);
		put_slew(8'd3);
		put_gains(32'h0000_0000, 32'h0000_0001, 32'h0000_0000);
		fast_flow = 1'b1;
		repeat (WIND_UP) send_sample(16'sh8000);
		settle();
		put_setpoint(16'sh8000);
		repeat (WIND_DOWN) send_sample(16'sh7FFF);
		settle();
		put_setpoint(16'sh7FFF);
		repeat (WIND_BACK) send_sample(16'sh8000);
		settle();
		fast_flow = 1'b0;

		random_phase = 1'b1;
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			put_setpoint(pick_setpoint());
			put_gains(pick_gain(26), pick_gain(14), pick_gain(26));
			put_slew(pick_slew());
			if ($urandom_range(0, 1) == 1) begin
				junk = $urandom();
				cfg_wr(CFG_INDEX_BITS'(int'(REG_FIRST_UNUSED) + $urandom_range(0, 2)), junk);
			end
			repeat (PHASE_ITEMS) send_sample(pick_sample());
			settle();
		end

		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin : watchdog
		#(TIMEOUT_NS);
		$display("FAIL");
		$finish;
	end

endmodule

// ===== files.f =====
sv/pidps_pkg.sv
sv/pidps_sample_if.sv
sv/pidps_drive_if.sv
sv/pidps_regs.sv
sv/pidps_error.sv
sv/pidps_mult.sv
sv/pidps_drive.sv
sv/pidps_slew.sv
sv/pid_position_slew_limited.sv
dv/pidps_loop_checker.sv
dv/tb.sv
